### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/rv64ie_pkg.sv
package rv64ie_pkg;

  localparam int DMEM_WORDS = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);
  localparam logic [63:0] DMEM_LIMIT    = 64'(DMEM_WORDS * 8);
  localparam logic [63:0] MEM_BASE_RST  = 64'h0000_0000_8000_0000;
  localparam logic [31:0] EBREAK_INSTR  = 32'h0010_0073;
  localparam logic [4:0]  REG_A0        = 5'd10;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMMW   = 7'h1b;
  localparam logic [6:0] OP_REGW   = 7'h3b;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULD = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_DIVW  = 3'd4;
  localparam logic [2:0] F3_REMW  = 3'd6;
  localparam logic [2:0] F3_REMUW = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FAULT   = 2'd3;

  typedef struct packed {
    logic [31:0] instr;
    logic [63:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [63:0] dest_value;
    logic [63:0] halt_value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_AGEN, S_MRD0, S_MRD1, S_MWR0, S_MWR1,
    S_MUL, S_DIV, S_DIVFIX, S_FIN
  } state_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

### rtl/rv64_instruction_execute_unit.sv
// Executes one RV64 instruction per transaction against an internal 32 x 64 register
// file and a DMEM_WORDS x 64 data memory. After reset the block sweeps the data memory
// to zero, one word per cycle (DMEM_WORDS words, 4096 by default), with busy high;
// cfg writes are taken at any time. An instruction is taken when start is high and busy
// is low; busy then stays high until the result is shown on out_data for one cycle with
// out_valid, and the next instruction may be started in that same cycle. The receiver
// cannot stall. Steps from start to out_valid: register file read, execute and
// writeback for ALU, jump, branch and ebreak; loads and stores add an address check
// and two one-word reads of the data memory, and stores then two one-word writes;
// mul and mulw form three 32x32 partial products on one multiplier; divw, remw and
// remuw find one quotient bit per cycle. Access faults end after the address check,
// and division by zero gives the architectural result from the execute step.
module rv64_instruction_execute_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rv64ie_pkg::in_item_t   in_data,
  output logic                   out_valid,
  output rv64ie_pkg::out_item_t  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [63:0]            cfg_data
);
  import rv64ie_pkg::*;

  state_t state_r, state_nxt;
  logic [31:0] instr_r, instr_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [63:0] val_r, val_nxt;
  logic [63:0] next_r, next_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        wr_r, wr_nxt;
  logic [63:0] halt_r, halt_nxt;
  logic [63:0] ea_r, ea_nxt;
  logic [2:0]  off_r, off_nxt;
  logic [DMEM_AW-1:0] idx_r, idx_nxt;
  logic [63:0] w0_r, w0_nxt, w1_r, w1_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [31:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic        negq_r, negq_nxt;
  logic [DMEM_AW-1:0] clr_r, clr_nxt;
  logic [63:0] mem_base_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic [31:0] rf_vld_r;

  logic [63:0] rf_mem [32];
  logic [63:0] rf_qa_r, rf_qb_r;
  logic        rf_va_r, rf_vb_r;
  logic [4:0]  rf_ra, rf_rb;
  logic        rf_re, rf_we;

  logic [63:0] dmem [DMEM_WORDS];
  logic [63:0] dm_q_r;
  logic [DMEM_AW-1:0] dm_ra, dm_wa, idx1;
  logic        dm_we;
  logic [63:0] dm_wd;

  logic [63:0] a, b;
  logic [6:0]  op, f7;
  logic [4:0]  rd, rs2;
  logic [2:0]  f3;
  logic [5:0]  sh6;
  logic [63:0] immi, imms, immb, immj, immu;
  logic        is_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign a    = rf_va_r ? rf_qa_r : 64'd0;
  assign b    = rf_vb_r ? rf_qb_r : 64'd0;
  assign op   = instr_r[6:0];
  assign rd   = instr_r[11:7];
  assign f3   = instr_r[14:12];
  assign rs2  = instr_r[24:20];
  assign f7   = instr_r[31:25];
  assign sh6  = {instr_r[25], instr_r[24:20]};
  assign is_w = (op == OP_REGW);
  assign immi = {{52{instr_r[31]}}, instr_r[31:20]};
  assign imms = {{52{instr_r[31]}}, instr_r[31:25], instr_r[11:7]};
  assign immb = {{51{instr_r[31]}}, instr_r[31], instr_r[7], instr_r[30:25],
                 instr_r[11:8], 1'b0};
  assign immj = {{43{instr_r[31]}}, instr_r[31], instr_r[19:12], instr_r[20],
                 instr_r[30:21], 1'b0};
  assign immu = {{32{instr_r[31]}}, instr_r[31:12], 12'd0};
  assign idx1 = (idx_r == DMEM_AW'(DMEM_WORDS - 1)) ? '0 : idx_r + 1'b1;

  // register file: two read ports, one write port
  assign rf_re = (state_r == S_IDLE) && start;
  assign rf_ra = (in_data.instr == EBREAK_INSTR) ? REG_A0 : in_data.instr[19:15];
  assign rf_rb = in_data.instr[24:20];

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[rd] <= val_r;
    end
    if (rf_re) begin
      rf_qa_r <= rf_mem[rf_ra];
      rf_qb_r <= rf_mem[rf_rb];
      rf_va_r <= rf_vld_r[rf_ra];
      rf_vb_r <= rf_vld_r[rf_rb];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_wa] <= dm_wd;
    end
    dm_q_r <= dmem[dm_ra];
  end

  always_comb begin
    logic        inv, take, sgn;
    logic [63:0] o, ld_raw, ld_val, bmask;
    logic [127:0] pair, sh_pair, mask128, data128, new_pair;
    logic [3:0]  size;
    logic [7:0]  bm;
    logic [31:0] a32, b32, mx, my, q32;
    logic [33:0] trial;

    state_nxt     = state_r;
    instr_nxt     = instr_r;
    pc_nxt        = pc_r;
    val_nxt       = val_r;
    next_nxt      = next_r;
    stat_nxt      = stat_r;
    wr_nxt        = wr_r;
    halt_nxt      = halt_r;
    ea_nxt        = ea_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    negq_nxt      = negq_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rf_we         = 1'b0;
    dm_we         = 1'b0;
    dm_wa         = idx_r;
    dm_wd         = 64'd0;
    dm_ra         = idx_r;

    inv     = 1'b0;
    take    = 1'b0;
    sgn     = 1'b0;
    size    = 4'd1 << f3[1:0];
    o       = ea_r - mem_base_r;
    a32     = a[31:0];
    b32     = b[31:0];
    mx      = a[31:0];
    my      = b[31:0];
    q32     = 32'd0;
    trial   = {1'b0, rem_r, quo_r[31]} - {2'b00, dvs_r};
    pair    = {dm_q_r, w0_r};
    sh_pair = pair >> {off_r, 3'b000};
    ld_raw  = sh_pair[63:0];
    ld_val  = ld_raw;
    case (f3[1:0])
      2'd0:    bm = 8'h01;
      2'd1:    bm = 8'h03;
      2'd2:    bm = 8'h0f;
      default: bm = 8'hff;
    endcase
    for (int i = 0; i < 8; i++) begin
      bmask[i*8 +: 8] = {8{bm[i]}};
    end
    mask128  = {64'd0, bmask} << {off_r, 3'b000};
    data128  = {64'd0, b} << {off_r, 3'b000};
    new_pair = (pair & ~mask128) | (data128 & mask128);

    unique case (state_r)
      S_CLEAR: begin
        dm_we   = 1'b1;
        dm_wa   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == DMEM_AW'(DMEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          instr_nxt = in_data.instr;
          pc_nxt    = in_data.pc;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        val_nxt   = 64'd0;
        next_nxt  = pc_r + 64'd4;
        stat_nxt  = ST_OK;
        wr_nxt    = 1'b0;
        halt_nxt  = 64'd0;
        state_nxt = S_FIN;
        unique case (op)
          OP_LUI: begin
            val_nxt = immu;
            wr_nxt  = 1'b1;
          end
          OP_AUIPC: begin
            val_nxt = pc_r + immu;
            wr_nxt  = 1'b1;
          end
          OP_JAL: begin
            val_nxt  = pc_r + 64'd4;
            next_nxt = pc_r + immj;
            wr_nxt   = 1'b1;
          end
          OP_JALR: begin
            if (f3 != 3'd0) begin
              inv = 1'b1;
            end
            val_nxt  = pc_r + 64'd4;
            next_nxt = (a + immi) & ~64'd1;
            wr_nxt   = 1'b1;
          end
          OP_BRANCH: begin
            case (f3)
              3'd0:    take = (a == b);
              3'd1:    take = (a != b);
              3'd4:    take = ($signed(a) < $signed(b));
              3'd5:    take = ($signed(a) >= $signed(b));
              3'd6:    take = (a < b);
              3'd7:    take = (a >= b);
              default: inv = 1'b1;
            endcase
            if (take) begin
              next_nxt = pc_r + immb;
            end
          end
          OP_LOAD: begin
            wr_nxt = 1'b1;
            ea_nxt = a + immi;
            if (f3 > 3'd5) begin
              inv = 1'b1;
            end else begin
              state_nxt = S_AGEN;
            end
          end
          OP_STORE: begin
            ea_nxt = a + imms;
            if (f3 > 3'd3) begin
              inv = 1'b1;
            end else begin
              state_nxt = S_AGEN;
            end
          end
          OP_IMM: begin
            wr_nxt = 1'b1;
            case (f3)
              3'd0: val_nxt = a + immi;
              3'd3: val_nxt = {63'd0, a < immi};
              3'd4: val_nxt = a ^ immi;
              3'd7: val_nxt = a & immi;
              3'd1: begin
                if (instr_r[31:26] == 6'h00) val_nxt = a << sh6;
                else inv = 1'b1;
              end
              3'd5: begin
                if (instr_r[31:26] == 6'h00) val_nxt = a >> sh6;
                else if (instr_r[31:26] == 6'h10) val_nxt = $signed(a) >>> sh6;
                else inv = 1'b1;
              end
              default: inv = 1'b1;
            endcase
          end
          OP_REG: begin
            wr_nxt = 1'b1;
            if (f7 == F7_BASE && f3 == 3'd0) val_nxt = a + b;
            else if (f7 == F7_BASE && f3 == 3'd2)
              val_nxt = {63'd0, $signed(a) < $signed(b)};
            else if (f7 == F7_BASE && f3 == 3'd3) val_nxt = {63'd0, a < b};
            else if (f7 == F7_BASE && f3 == 3'd6) val_nxt = a | b;
            else if (f7 == F7_BASE && f3 == 3'd7) val_nxt = a & b;
            else if (f7 == F7_MULD && f3 == 3'd0) begin
              cnt_nxt   = 5'd0;
              state_nxt = S_MUL;
            end
            else if (f7 == F7_ALT && f3 == 3'd0) val_nxt = a - b;
            else if (f7 == F7_ALT && f3 == 3'd5) val_nxt = $signed(a) >>> b[5:0];
            else inv = 1'b1;
          end
          OP_IMMW: begin
            wr_nxt = 1'b1;
            if (f3 == 3'd0) val_nxt = sx32(a32 + immi[31:0]);
            else if (f3 == 3'd1 && f7 == F7_BASE) val_nxt = sx32(a32 << rs2);
            else if (f3 == 3'd5 && f7 == F7_BASE) val_nxt = sx32(a32 >> rs2);
            else if (f3 == 3'd5 && f7 == F7_ALT)
              val_nxt = sx32($signed(a32) >>> rs2);
            else inv = 1'b1;
          end
          OP_REGW: begin
            wr_nxt = 1'b1;
            if (f7 == F7_BASE && f3 == 3'd0) val_nxt = sx32(a32 + b32);
            else if (f7 == F7_BASE && f3 == 3'd1) val_nxt = sx32(a32 << b[4:0]);
            else if (f7 == F7_BASE && f3 == 3'd5) val_nxt = sx32(a32 >> b[4:0]);
            else if (f7 == F7_ALT && f3 == 3'd0) val_nxt = sx32(a32 - b32);
            else if (f7 == F7_ALT && f3 == 3'd5)
              val_nxt = sx32($signed(a32) >>> b[4:0]);
            else if (f7 == F7_MULD && f3 == 3'd0) begin
              cnt_nxt   = 5'd0;
              state_nxt = S_MUL;
            end
            else if (f7 == F7_MULD &&
                     (f3 == F3_DIVW || f3 == F3_REMW || f3 == F3_REMUW)) begin
              if (b32 == 32'd0) begin
                val_nxt = (f3 == F3_DIVW) ? '1 : sx32(a32);
              end else begin
                sgn       = (f3 != F3_REMUW);
                quo_nxt   = (sgn && a32[31]) ? -a32 : a32;
                dvs_nxt   = (sgn && b32[31]) ? -b32 : b32;
                negq_nxt  = sgn && (a32[31] ^ ((f3 == F3_DIVW) && b32[31]));
                rem_nxt   = 32'd0;
                cnt_nxt   = 5'd31;
                state_nxt = S_DIV;
              end
            end
            else inv = 1'b1;
          end
          OP_SYSTEM: begin
            if (instr_r == EBREAK_INSTR) begin
              stat_nxt = ST_HALT;
              halt_nxt = a;
            end else begin
              inv = 1'b1;
            end
          end
          default: inv = 1'b1;
        endcase
        if (inv) begin
          stat_nxt  = ST_INVALID;
          state_nxt = S_FIN;
        end
      end
      S_AGEN: begin
        if (o > DMEM_LIMIT - 64'(size)) begin
          stat_nxt  = ST_FAULT;
          state_nxt = S_FIN;
        end else begin
          off_nxt   = o[2:0];
          idx_nxt   = o[DMEM_AW+2:3];
          dm_ra     = o[DMEM_AW+2:3];
          state_nxt = S_MRD0;
        end
      end
      S_MRD0: begin
        w0_nxt    = dm_q_r;
        dm_ra     = idx1;
        state_nxt = S_MRD1;
      end
      S_MRD1: begin
        if (op == OP_LOAD) begin
          case (f3)
            3'd0:    ld_val = {{56{ld_raw[7]}}, ld_raw[7:0]};
            3'd1:    ld_val = {{48{ld_raw[15]}}, ld_raw[15:0]};
            3'd2:    ld_val = sx32(ld_raw[31:0]);
            3'd4:    ld_val = {56'd0, ld_raw[7:0]};
            3'd5:    ld_val = {48'd0, ld_raw[15:0]};
            default: ld_val = ld_raw;
          endcase
          val_nxt   = ld_val;
          state_nxt = S_FIN;
        end else begin
          w0_nxt    = new_pair[63:0];
          w1_nxt    = new_pair[127:64];
          state_nxt = S_MWR0;
        end
      end
      S_MWR0: begin
        dm_we     = 1'b1;
        dm_wa     = idx_r;
        dm_wd     = w0_r;
        state_nxt = S_MWR1;
      end
      S_MWR1: begin
        dm_we     = 1'b1;
        dm_wa     = idx1;
        dm_wd     = w1_r;
        state_nxt = S_FIN;
      end
      S_MUL: begin
        // low 64 bits: al*bl + ((al*bh + ah*bl) << 32)
        case (cnt_r[1:0])
          2'd0: begin
            mx = a[31:0];
            my = b[31:0];
          end
          2'd1: begin
            mx = a[31:0];
            my = b[63:32];
            acc_nxt = prod_r;
          end
          2'd2: begin
            mx = a[63:32];
            my = b[31:0];
            acc_nxt = acc_r + {prod_r[31:0], 32'd0};
          end
          default: begin
            acc_nxt = acc_r + {prod_r[31:0], 32'd0};
          end
        endcase
        prod_nxt = 64'(mx) * 64'(my);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          val_nxt   = is_w ? sx32(acc_nxt[31:0]) : acc_nxt;
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (!trial[33]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_DIVFIX;
        end
      end
      S_DIVFIX: begin
        q32       = (f3 == F3_DIVW) ? quo_r : rem_r;
        val_nxt   = sx32(negq_r ? -q32 : q32);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        rf_we                    = wr_r && (stat_r == ST_OK) && (rd != 5'd0);
        out_valid_nxt            = 1'b1;
        out_data_nxt.status      = stat_r;
        out_data_nxt.next_pc     = (stat_r == ST_INVALID || stat_r == ST_FAULT) ?
                                   pc_r : next_r;
        out_data_nxt.reg_written = rf_we;
        out_data_nxt.dest_reg    = rf_we ? rd : 5'd0;
        out_data_nxt.dest_value  = rf_we ? val_r : 64'd0;
        out_data_nxt.halt_value  = halt_r;
        state_nxt                = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      mem_base_r  <= MEM_BASE_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_vld_r[rd] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        mem_base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    instr_r    <= instr_nxt;
    pc_r       <= pc_nxt;
    val_r      <= val_nxt;
    next_r     <= next_nxt;
    stat_r     <= stat_nxt;
    wr_r       <= wr_nxt;
    halt_r     <= halt_nxt;
    ea_r       <= ea_nxt;
    off_r      <= off_nxt;
    idx_r      <= idx_nxt;
    w0_r       <= w0_nxt;
    w1_r       <= w1_nxt;
    cnt_r      <= cnt_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    negq_r     <= negq_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/rv64ie_checker.sv
`include "assert_macros.svh"

module rv64ie_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input rv64ie_pkg::in_item_t   in_data,
  input logic                   out_valid,
  input rv64ie_pkg::out_item_t  out_data,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [63:0]            cfg_data
);
  import rv64ie_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_data, cfg_valid, cfg_ready, cfg_data};

  // an accepted transaction makes the block busy in the cycle after it
  `ASSERT_NXT(a_accept_busy, start && !busy, busy)
  // a result always follows a busy cycle, so two never come back to back
  `ASSERT_IMP(a_res_after_busy, out_valid, $past(busy) && !$past(out_valid))
  // x0 is never reported as written
  `ASSERT_IMP(a_no_x0_write, out_valid && out_data.reg_written, out_data.dest_reg != 5'd0)
  // a failed instruction writes nothing
  `ASSERT_IMP(a_fail_no_write,
              out_valid && (out_data.status == ST_INVALID || out_data.status == ST_FAULT),
              !out_data.reg_written && out_data.dest_value == 64'd0)

endmodule

bind rv64_instruction_execute_unit rv64ie_checker u_rv64ie_checker (.*);
